// ===== design/sha2_pkg.sv =====
// ----------------------------------------------------------------------------
// sha2_pkg
// Shared types, constants and SHA-2 bit functions for the SHA-224/256 engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sha2_pkg;

    typedef logic [31:0]       word_t;
    typedef logic [7:0][31:0]  hash_t;
    typedef logic [15:0][31:0] blk_t;

    // command codes on the input stream
    localparam logic [1:0] FUNC_APPEND  = 2'd0;
    localparam logic [1:0] FUNC_DIGEST  = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // register byte addresses
    localparam logic [2:0] ADDR_HASH_MODE = 3'd0;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [63:0][31:0] ROUND_K = {
        32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
        32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
        32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
        32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
        32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
        32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
        32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
        32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
        32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
        32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
        32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
        32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
        32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
        32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
        32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
        32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
    };

    // word 0 (a) sits in the lowest slot
    localparam hash_t INIT_224 = {
        32'hbefa4fa4, 32'h64f98fa7, 32'h68581511, 32'hffc00b31,
        32'hf70e5939, 32'h3070dd17, 32'h367cd507, 32'hc1059ed8
    };
    localparam hash_t INIT_256 = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic word_t rotr(input word_t x, input logic [4:0] n);
        rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
    endfunction

endpackage
`default_nettype wire

// ===== design/sha2_sched.sv =====
// ----------------------------------------------------------------------------
// sha2_sched
// Message schedule: sixteen-word shift line producing one W word per round.
// ----------------------------------------------------------------------------
`default_nettype none
module sha2_sched (
    input  wire logic           aclk,
    input  wire logic           load,
    input  wire sha2_pkg::blk_t load_words,
    input  wire logic           advance,
    output sha2_pkg::word_t     w_out
);

    sha2_pkg::blk_t  w_reg;
    sha2_pkg::blk_t  w_next;
    sha2_pkg::word_t w_new;

    // next schedule word from the sixteen-word window
    assign w_new = sha2_pkg::sig1(w_reg[14]) + w_reg[9]
                 + sha2_pkg::sig0(w_reg[1]) + w_reg[0];

    always_comb begin
        w_next = w_reg;
        if (load) begin
            w_next = load_words;
        end else if (advance) begin
            w_next = {w_new, w_reg[15:1]};
        end
    end

    always_ff @(posedge aclk) begin
        w_reg <= w_next;
    end

    assign w_out = w_reg[0];

endmodule
`default_nettype wire

// ===== design/sha2_round.sv =====
// ----------------------------------------------------------------------------
// sha2_round
// One SHA-256 compression round, shared over all 64 rounds of a block.
// ----------------------------------------------------------------------------
`default_nettype none
module sha2_round (
    input  wire sha2_pkg::hash_t v_in,
    input  wire sha2_pkg::word_t k,
    input  wire sha2_pkg::word_t w,
    output sha2_pkg::hash_t      v_out
);

    sha2_pkg::word_t t1;
    sha2_pkg::word_t t2;
    sha2_pkg::word_t ch;
    sha2_pkg::word_t maj;

    // choose and majority on e,f,g and a,b,c
    assign ch  = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
    assign maj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
    assign t1  = v_in[7] + sha2_pkg::bsig1(v_in[4]) + ch + k + w;
    assign t2  = sha2_pkg::bsig0(v_in[0]) + maj;

    assign v_out = {v_in[6], v_in[5], v_in[4], v_in[3] + t1,
                    v_in[2], v_in[1], v_in[0], t1 + t2};

endmodule
`default_nettype wire

// ===== design/sha256_sha224_hash_engine_core.sv =====
// ----------------------------------------------------------------------------
// sha256_sha224_hash_engine_core
// Streaming SHA-224/SHA-256 hasher with lowercase hex digest output.
// ----------------------------------------------------------------------------
// An append transfer stores one byte; every 64th byte runs a block
// compression (one load, 64 rounds on the shared round unit, one add),
// during which s_tready is low. A digest compresses one or two padded
// blocks (two when 56 or more bytes sit in the buffer) and then streams
// 56 or 64 hex characters, one per cycle on m_tready. The stored hash is
// untouched by a digest, so appending may go on afterwards.
`default_nettype none
module sha256_sha224_hash_engine_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [1:0] func, [9:2] data_byte, rest zero
    // stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [6:0] hex_char, [7] zero
    output logic             m_tlast,   // last
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic            hash_mode_reg;
    logic            mode_reg, mode_next;
    sha2_pkg::hash_t hash_reg, hash_next;
    sha2_pkg::hash_t work_reg, work_next;
    sha2_pkg::hash_t v_reg, v_next;
    sha2_pkg::blk_t  buf_reg;
    logic [5:0]      fill_reg, fill_next;
    logic [63:0]     count_reg, count_next;
    logic [5:0]      rnd_reg, rnd_next;
    logic [5:0]      idx_reg, idx_next;
    logic            dig_reg, dig_next;
    logic            second_reg, second_next;

    logic            s_xfer;
    logic            m_xfer;
    logic [1:0]      func;
    logic [7:0]      data_byte;
    logic            two_blk;
    sha2_pkg::blk_t  blk_words;
    sha2_pkg::hash_t v_round;
    sha2_pkg::word_t w_t;
    logic            last_char;
    sha2_pkg::word_t out_word;
    logic [3:0]      nib;
    logic [6:0]      hex_char;

    assign func      = s_tdata[1:0];
    assign data_byte = s_tdata[9:2];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_xfer    = m_tvalid && m_tready;
    assign two_blk   = (fill_reg[5:3] == 3'd7);

    // register port
    assign pready = 1'b1;
    assign prdata = {31'd0, hash_mode_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_mode_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == sha2_pkg::ADDR_HASH_MODE[2]) begin
            hash_mode_reg <= pwdata[0];
        end
    end

    // block words with padding and bit length applied as needed
    always_comb begin
        logic [5:0]  k;
        logic [7:0]  b;
        logic [63:0] bits;
        bits = {count_reg[60:0], 3'b000};
        for (int i = 0; i < 64; i++) begin
            k = 6'(i);
            b = buf_reg[k[5:2]][8 * (3 - i % 4) +: 8];
            if (dig_reg) begin
                if (second_reg || k > fill_reg) begin
                    b = 8'd0;
                end else if (k == fill_reg) begin
                    b = sha2_pkg::PAD_BYTE;
                end
                if ((second_reg || !two_blk) && k[5:3] == 3'd7) begin
                    b = bits[8 * (7 - i % 8) +: 8];
                end
            end
            blk_words[k[5:2]][8 * (3 - i % 4) +: 8] = b;
        end
    end

    sha2_sched u_sched (
        .aclk       (aclk),
        .load       (state_reg == ST_LOAD),
        .load_words (blk_words),
        .advance    (state_reg == ST_ROUND),
        .w_out      (w_t)
    );

    sha2_round u_round (
        .v_in  (v_reg),
        .k     (sha2_pkg::ROUND_K[rnd_reg]),
        .w     (w_t),
        .v_out (v_round)
    );

    // message buffer byte write
    always_ff @(posedge aclk) begin
        if (s_xfer && func == sha2_pkg::FUNC_APPEND) begin
            buf_reg[fill_reg[5:2]][8 * (3 - fill_reg[1:0]) +: 8] <= data_byte;
        end
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        hash_next   = hash_reg;
        work_next   = work_reg;
        v_next      = v_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        rnd_next    = rnd_reg;
        idx_next    = idx_reg;
        dig_next    = dig_reg;
        second_next = second_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    case (func)
                        sha2_pkg::FUNC_APPEND: begin
                            fill_next  = fill_reg + 6'd1;
                            count_next = count_reg + 64'd1;
                            work_next  = hash_reg;
                            dig_next   = 1'b0;
                            if (fill_reg == 6'd63) begin
                                state_next = ST_LOAD;
                            end
                        end
                        sha2_pkg::FUNC_DIGEST: begin
                            work_next   = hash_reg;
                            dig_next    = 1'b1;
                            second_next = 1'b0;
                            state_next  = ST_LOAD;
                        end
                        sha2_pkg::FUNC_RESTART: begin
                            mode_next  = hash_mode_reg;
                            hash_next  = hash_mode_reg ? sha2_pkg::INIT_256
                                                       : sha2_pkg::INIT_224;
                            fill_next  = 6'd0;
                            count_next = 64'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                v_next     = work_reg;
                rnd_next   = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                v_next   = v_round;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    work_next[i] = work_reg[i] + v_reg[i];
                end
                if (!dig_reg) begin
                    hash_next  = work_next;
                    state_next = ST_IDLE;
                end else if (two_blk && !second_reg) begin
                    second_next = 1'b1;
                    state_next  = ST_LOAD;
                end else begin
                    idx_next   = 6'd0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_xfer) begin
                    idx_next = idx_reg + 6'd1;
                    if (last_char) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mode_reg   <= 1'b1;
            hash_reg   <= sha2_pkg::INIT_256;
            fill_reg   <= 6'd0;
            count_reg  <= 64'd0;
            rnd_reg    <= 6'd0;
            idx_reg    <= 6'd0;
            dig_reg    <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            hash_reg   <= hash_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            rnd_reg    <= rnd_next;
            idx_reg    <= idx_next;
            dig_reg    <= dig_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        v_reg    <= v_next;
    end

    // hex character from the digest, most significant nibble first
    assign out_word  = work_reg[idx_reg[5:3]];
    assign nib       = 4'(out_word >> {~idx_reg[2:0], 2'b00});
    assign hex_char  = (nib < 4'd10) ? 7'd48 + {3'd0, nib} : 7'd87 + {3'd0, nib};
    assign last_char = (idx_reg == (mode_reg ? 6'd63 : 6'd55));
    assign m_tdata   = {1'b0, hex_char};
    assign m_tlast   = last_char;

    // checks
    a_out_blocks_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while digest is streaming");

    a_round_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> state_reg == ST_ADD)
        else $error("compression did not end after 64 rounds");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && m_tlast) |=> state_reg == ST_IDLE)
        else $error("digest stream did not end on last character");

    a_block_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && func == sha2_pkg::FUNC_APPEND && fill_reg == 6'd63)
        |=> state_reg == ST_LOAD && fill_reg == 6'd0)
        else $error("full block did not start compression");

endmodule
`default_nettype wire
